// ===== rtl/eip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package eip_pkg;

  localparam int unsigned MaxFrameBytesDefault = 65535;

  localparam int unsigned EthHdrBytes = 14;
  localparam int unsigned IpMinBytes  = 20;
  localparam int unsigned TcpMinBytes = 20;
  localparam int unsigned UdpHdrBytes = 8;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [3:0]  IpVersion4    = 4'd4;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;

  localparam int unsigned OutDataBits = 272;

  localparam logic [2:0] StTcpOk      = 3'd0;
  localparam logic [2:0] StUdpOk      = 3'd1;
  localparam logic [2:0] StEthTrunc   = 3'd2;
  localparam logic [2:0] StNonIpv4    = 3'd3;
  localparam logic [2:0] StBadIpv4    = 3'd4;
  localparam logic [2:0] StFragment   = 3'd5;
  localparam logic [2:0] StOtherProto = 3'd6;
  localparam logic [2:0] StBadL4      = 3'd7;

  typedef struct packed {
    logic [15:0] cap_len;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] eth_type;
    logic [7:0]  version_ihl;
    logic [15:0] frag_field;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [3:0]  tcp_offset;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/eip_capture.sv =====
`timescale 1ns / 1ps
`default_nettype none

module eip_capture #(
  parameter int unsigned MAX_FRAME_BYTES = eip_pkg::MaxFrameBytesDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire logic [7:0]     data_i,
  input  wire logic           last_i,
  output logic                ready_o,
  input  wire logic           snap_ready_i,
  output logic                snap_valid_o,
  output eip_pkg::frame_t     snap_o
);

  eip_pkg::frame_t held_q, held_d;
  eip_pkg::frame_t snap_q;
  logic            snap_valid_q, snap_valid_d;
  logic            accept;
  logic [15:0]     pos;
  logic [3:0]      ihl;
  logic [15:0]     l4;

  assign ready_o      = !snap_valid_q || snap_ready_i;
  assign accept       = valid_i && ready_o;
  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  assign pos = held_q.cap_len;
  assign ihl = held_q.version_ihl[3:0];
  assign l4  = 16'(eip_pkg::EthHdrBytes) + {10'd0, ihl, 2'b00};

  always_comb begin
    held_d = held_q;
    if (pos < 16'(MAX_FRAME_BYTES)) begin
      if (pos <= 16'd5) begin
        held_d.dst_mac = {held_q.dst_mac[39:0], data_i};
      end else if (pos <= 16'd11) begin
        held_d.src_mac = {held_q.src_mac[39:0], data_i};
      end else if (pos <= 16'd13) begin
        held_d.eth_type = {held_q.eth_type[7:0], data_i};
      end else if (pos == 16'd14) begin
        held_d.version_ihl = data_i;
      end else if (pos == 16'd20 || pos == 16'd21) begin
        held_d.frag_field = {held_q.frag_field[7:0], data_i};
      end else if (pos == 16'd23) begin
        held_d.protocol = data_i;
      end else if (pos >= 16'd26 && pos <= 16'd29) begin
        held_d.src_ip = {held_q.src_ip[23:0], data_i};
      end else if (pos >= 16'd30 && pos <= 16'd33) begin
        held_d.dst_ip = {held_q.dst_ip[23:0], data_i};
      end
      if (ihl >= 4'd5 && pos >= 16'd15) begin
        if (pos == l4 || pos == l4 + 16'd1) begin
          held_d.src_port = {held_q.src_port[7:0], data_i};
        end else if (pos == l4 + 16'd2 || pos == l4 + 16'd3) begin
          held_d.dst_port = {held_q.dst_port[7:0], data_i};
        end else if (pos == l4 + 16'd12) begin
          held_d.tcp_offset = data_i[7:4];
        end
      end
      held_d.cap_len = pos + 16'd1;
    end
  end

  always_comb begin
    snap_valid_d = snap_valid_q;
    if (accept && last_i) begin
      snap_valid_d = 1'b1;
    end else if (snap_ready_i) begin
      snap_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
      if (accept) begin
        if (last_i) begin
          held_q <= '0;
        end else begin
          held_q <= held_d;
        end
      end
    end
  end

  // frame snapshot, taken on the last beat
  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      snap_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eip_result.sv =====
`timescale 1ns / 1ps
`default_nettype none

module eip_result (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              snap_valid_i,
  input  wire eip_pkg::frame_t                   snap_i,
  output logic                                   ready_o,
  output logic                                   valid_o,
  input  wire logic                              out_ready_i,
  output logic [eip_pkg::OutDataBits-1:0]        data_o
);

  logic                              out_valid_q, out_valid_d;
  logic [eip_pkg::OutDataBits-1:0]   out_data_q, out_data_d;
  logic [2:0]                        status;
  logic [15:0]                       cap;
  logic [7:0]                        ip_end;
  logic [7:0]                        tcp_len;
  logic [15:0]                       rem;
  logic [7:0]                        hdr_end;
  logic [15:0]                       hdr_len;
  logic [15:0]                       pay_len;
  logic [15:0]                       sport;
  logic [15:0]                       dport;

  assign ready_o = !out_valid_q || out_ready_i;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  assign cap     = snap_i.cap_len;
  assign ip_end  = 8'(eip_pkg::EthHdrBytes) + {2'b00, snap_i.version_ihl[3:0], 2'b00};
  assign tcp_len = {2'b00, snap_i.tcp_offset, 2'b00};
  assign rem     = cap - {8'd0, ip_end};

  always_comb begin
    hdr_end = ip_end;
    if (cap < 16'(eip_pkg::EthHdrBytes)) begin
      status = eip_pkg::StEthTrunc;
    end else if (snap_i.eth_type != eip_pkg::EtherTypeIpv4) begin
      status = eip_pkg::StNonIpv4;
    end else if (cap < 16'(eip_pkg::EthHdrBytes + eip_pkg::IpMinBytes)) begin
      status = eip_pkg::StBadIpv4;
    end else if (snap_i.version_ihl[7:4] != eip_pkg::IpVersion4 ||
                 snap_i.version_ihl[3:0] < 4'd5 || cap < {8'd0, ip_end}) begin
      status = eip_pkg::StBadIpv4;
    end else if (snap_i.frag_field[12:0] != 13'd0) begin
      status = eip_pkg::StFragment;
    end else if (snap_i.protocol == eip_pkg::ProtoTcp) begin
      if (rem < 16'(eip_pkg::TcpMinBytes) || tcp_len < 8'(eip_pkg::TcpMinBytes) ||
          rem < {8'd0, tcp_len}) begin
        status = eip_pkg::StBadL4;
      end else begin
        status  = eip_pkg::StTcpOk;
        hdr_end = ip_end + tcp_len;
      end
    end else if (snap_i.protocol == eip_pkg::ProtoUdp) begin
      if (rem < 16'(eip_pkg::UdpHdrBytes)) begin
        status = eip_pkg::StBadL4;
      end else begin
        status  = eip_pkg::StUdpOk;
        hdr_end = ip_end + 8'(eip_pkg::UdpHdrBytes);
      end
    end else begin
      status = eip_pkg::StOtherProto;
    end
  end

  always_comb begin
    hdr_len = 16'd0;
    pay_len = 16'd0;
    sport   = 16'd0;
    dport   = 16'd0;
    if (status == eip_pkg::StTcpOk || status == eip_pkg::StUdpOk) begin
      hdr_len = {8'd0, hdr_end};
      pay_len = cap - {8'd0, hdr_end};
    end
    if (status == eip_pkg::StTcpOk || status == eip_pkg::StUdpOk ||
        status == eip_pkg::StBadL4) begin
      sport = snap_i.src_port;
      dport = snap_i.dst_port;
    end
  end

  assign out_data_d = {5'd0, cap, pay_len, hdr_len, dport, sport, snap_i.protocol,
                       snap_i.dst_ip, snap_i.src_ip, snap_i.eth_type,
                       snap_i.dst_mac, snap_i.src_mac, status};

  always_comb begin
    out_valid_d = out_valid_q;
    if (ready_o) begin
      out_valid_d = snap_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && snap_valid_i) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eth_ipv4_l4_header_parser.sv =====
// throughput: one input beat per cycle while s_axis_tready_o is high, one result per frame
// input and output are parted by a snapshot register and a result register
// reset clears the byte count, all captured fields and both valid flags
`timescale 1ns / 1ps
`default_nettype none

module eth_ipv4_l4_header_parser #(
  parameter int unsigned MAX_FRAME_BYTES = eip_pkg::MaxFrameBytesDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [7:0]                   s_axis_tdata_i,  // data_byte
  input  wire logic                         s_axis_tlast_i,  // last_byte
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // status, source_mac, dest_mac, eth_type, source_ip, dest_ip, ip_protocol,
  // source_port, dest_port, header_length, payload_length, captured_length
  output logic [eip_pkg::OutDataBits-1:0]   m_axis_tdata_o
);

  logic            snap_valid;
  logic            snap_ready;
  eip_pkg::frame_t snap;

  eip_capture #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid_i),
    .data_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .ready_o     (s_axis_tready_o),
    .snap_ready_i(snap_ready),
    .snap_valid_o(snap_valid),
    .snap_o      (snap)
  );

  eip_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_valid_i(snap_valid),
    .snap_i      (snap),
    .ready_o     (snap_ready),
    .valid_o     (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .data_o      (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import eip_pkg::*;

  typedef enum logic [1:0] {
    FrameHeaders,
    FrameFill,
    FrameNoise
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e kind;
    logic [7:0]  fill;
    logic [15:0] eth_type;
    logic [7:0]  ver_ihl;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [3:0]  tcp_off;
    logic [31:0] len;
    logic        typed;
    logic [2:0]  exp_status;
    logic [15:0] exp_cap;
  } recipe_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] captured_length;
    logic [15:0] payload_length;
    logic [15:0] header_length;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [7:0]  ip_protocol;
    logic [31:0] dest_ip;
    logic [31:0] source_ip;
    logic [15:0] eth_type;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [2:0]  status;
  } summary_t;

  localparam recipe_t DirectedFrames [20] = '{
    '{FrameFill,    8'hFF, 16'h0000, 8'h00, 16'h0000, 8'h00,     4'd0,  1,     1'b1, StEthTrunc,   16'd1},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h45, 16'h0000, ProtoTcp,  4'd5,  13,    1'b1, StEthTrunc,   16'd13},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h45, 16'h0000, ProtoTcp,  4'd5,  14,    1'b1, StBadIpv4,    16'd14},
    '{FrameHeaders, 8'h00, 16'h86DD, 8'h45, 16'h0000, ProtoTcp,  4'd5,  20,    1'b1, StNonIpv4,    16'd20},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h45, 16'h0000, ProtoTcp,  4'd5,  54,    1'b1, StTcpOk,      16'd54},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h45, 16'h0000, ProtoUdp,  4'd5,  42,    1'b1, StUdpOk,      16'd42},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h65, 16'h0000, ProtoTcp,  4'd5,  34,    1'b1, StBadIpv4,    16'd34},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h44, 16'h0000, ProtoTcp,  4'd5,  34,    1'b1, StBadIpv4,    16'd34},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h4F, 16'h0000, ProtoTcp,  4'd5,  100,   1'b1, StTcpOk,      16'd100},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h45, 16'h1FFF, ProtoTcp,  4'd5,  34,    1'b1, StFragment,   16'd34},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h45, 16'hE000, ProtoTcp,  4'd5,  54,    1'b1, StTcpOk,      16'd54},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h45, 16'h0000, 8'h01,     4'd5,  34,    1'b1, StOtherProto, 16'd34},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h45, 16'h0000, ProtoTcp,  4'd4,  54,    1'b1, StBadL4,      16'd54},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h45, 16'h0000, ProtoTcp,  4'd5,  53,    1'b1, StBadL4,      16'd53},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h45, 16'h0000, ProtoUdp,  4'd5,  41,    1'b1, StBadL4,      16'd41},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h4F, 16'h0000, ProtoTcp,  4'd5,  73,    1'b1, StBadIpv4,    16'd73},
    '{FrameFill,    8'hFF, 16'h0000, 8'h00, 16'h0000, 8'h00,     4'd0,  20,    1'b1, StNonIpv4,    16'd20},
    '{FrameFill,    8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00,     4'd0,  20,    1'b1, StNonIpv4,    16'd20},
    '{FrameNoise,   8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00,     4'd0,  40,    1'b0, StTcpOk,      16'd0},
    '{FrameHeaders, 8'h00, 16'h0800, 8'h46, 16'h0000, ProtoUdp,  4'd5,  50,    1'b0, StTcpOk,      16'd0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [7:0]             s_axis_tdata_i;
  logic                   s_axis_tlast_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OutDataBits-1:0] m_axis_tdata_o;

  eth_ipv4_l4_header_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // data_byte
    .s_axis_tlast_i (s_axis_tlast_i),   // last_byte
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    // status, source_mac, dest_mac, eth_type, source_ip, dest_ip, ip_protocol,
    // source_port, dest_port, header_length, payload_length, captured_length
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  summary_t    pending_summaries[$];
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  logic        steady;

  int unsigned fr_pos;
  logic [47:0] fr_src_mac;
  logic [47:0] fr_dst_mac;
  logic [15:0] fr_eth_type;
  logic [7:0]  fr_ver_ihl;
  logic [15:0] fr_frag;
  logic [7:0]  fr_proto;
  logic [31:0] fr_src_ip;
  logic [31:0] fr_dst_ip;
  logic [3:0]  fr_tcp_off;
  logic [15:0] fr_src_port;
  logic [15:0] fr_dst_port;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  task automatic clear_frame();
    fr_pos        = 0;
    fr_src_mac    = '0;
    fr_dst_mac    = '0;
    fr_eth_type   = '0;
    fr_ver_ihl    = '0;
    fr_frag       = '0;
    fr_proto      = '0;
    fr_src_ip     = '0;
    fr_dst_ip     = '0;
    fr_tcp_off    = '0;
    fr_src_port   = '0;
    fr_dst_port   = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input bit last, output bit got,
                            output summary_t r);
    int unsigned ihl;
    int unsigned l4;
    int unsigned cap;
    int unsigned off;
    int unsigned hlen;
    int unsigned tl;
    logic [2:0]  st;
    got = 1'b0;
    r   = '0;
    off = 0;
    if (fr_pos < MaxFrameBytesDefault) begin
      ihl = fr_ver_ihl[3:0];
      if (fr_pos <= 5) fr_dst_mac = {fr_dst_mac[39:0], b};
      else if (fr_pos <= 11) fr_src_mac = {fr_src_mac[39:0], b};
      else if (fr_pos <= 13) fr_eth_type = {fr_eth_type[7:0], b};
      else if (fr_pos == 14) fr_ver_ihl = b;
      else if (fr_pos == 20 || fr_pos == 21) fr_frag = {fr_frag[7:0], b};
      else if (fr_pos == 23) fr_proto = b;
      else if (fr_pos >= 26 && fr_pos <= 29) fr_src_ip = {fr_src_ip[23:0], b};
      else if (fr_pos >= 30 && fr_pos <= 33) fr_dst_ip = {fr_dst_ip[23:0], b};
      if (ihl >= 5 && fr_pos >= 15) begin
        l4 = EthHdrBytes + ihl * 4;
        if (fr_pos == l4 || fr_pos == l4 + 1) fr_src_port = {fr_src_port[7:0], b};
        else if (fr_pos == l4 + 2 || fr_pos == l4 + 3) fr_dst_port = {fr_dst_port[7:0], b};
        else if (fr_pos == l4 + 12) fr_tcp_off = b[7:4];
      end
      fr_pos++;
    end
    if (!last) return;
    cap = fr_pos;
    if (cap < EthHdrBytes) begin
      st = StEthTrunc;
    end else if (fr_eth_type != EtherTypeIpv4) begin
      st = StNonIpv4;
    end else if (cap - EthHdrBytes < IpMinBytes) begin
      st = StBadIpv4;
    end else begin
      hlen = 32'(fr_ver_ihl[3:0]) * 4;
      if (fr_ver_ihl[7:4] != IpVersion4 || hlen < IpMinBytes || cap - EthHdrBytes < hlen) begin
        st = StBadIpv4;
      end else begin
        off = EthHdrBytes + hlen;
        if (fr_frag[12:0] != 13'd0) begin
          st = StFragment;
        end else if (fr_proto == ProtoTcp) begin
          tl = 32'(fr_tcp_off) * 4;
          if (cap - off < TcpMinBytes || tl < TcpMinBytes || cap - off < tl) begin
            st = StBadL4;
          end else begin
            off += tl;
            st = StTcpOk;
          end
        end else if (fr_proto == ProtoUdp) begin
          if (cap - off < UdpHdrBytes) begin
            st = StBadL4;
          end else begin
            off += UdpHdrBytes;
            st = StUdpOk;
          end
        end else begin
          st = StOtherProto;
        end
      end
    end
    r.status      = st;
    r.source_mac  = fr_src_mac;
    r.dest_mac    = fr_dst_mac;
    r.eth_type    = fr_eth_type;
    r.source_ip   = fr_src_ip;
    r.dest_ip     = fr_dst_ip;
    r.ip_protocol = fr_proto;
    if (st == StTcpOk || st == StUdpOk) begin
      r.header_length  = 16'(off);
      r.payload_length = 16'(cap - off);
    end
    if (st == StTcpOk || st == StUdpOk || st == StBadL4) begin
      r.source_port = fr_src_port;
      r.dest_port   = fr_dst_port;
    end
    r.captured_length = 16'(cap);
    got = 1'b1;
    clear_frame();
  endtask

  function automatic logic [7:0] frame_byte(input recipe_t rec, input int unsigned p);
    int unsigned ihl;
    int unsigned l4;
    logic [7:0]  b;
    b   = 8'($urandom_range(0, 255));
    ihl = rec.ver_ihl[3:0];
    l4  = EthHdrBytes + ((ihl >= 5) ? ihl * 4 : IpMinBytes);
    if (rec.kind == FrameFill) return rec.fill;
    if (rec.kind == FrameNoise) return b;
    if (p == 12) b = rec.eth_type[15:8];
    else if (p == 13) b = rec.eth_type[7:0];
    else if (p == 14) b = rec.ver_ihl;
    else if (p == 20) b = rec.frag[15:8];
    else if (p == 21) b = rec.frag[7:0];
    else if (p == 23) b = rec.proto;
    else if (p == l4 + 12) b = {rec.tcp_off, b[3:0]};
    return b;
  endfunction

  function automatic recipe_t random_frame();
    recipe_t     rec;
    int unsigned pick;
    int unsigned ihl;
    int unsigned full;
    rec            = '0;
    rec.kind       = FrameHeaders;
    rec.eth_type   = EtherTypeIpv4;
    ihl            = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    rec.ver_ihl    = {IpVersion4, 4'(ihl)};
    rec.frag       = {3'($urandom_range(0, 7)), 13'd0};
    rec.proto      = $urandom_range(0, 1) ? ProtoTcp : ProtoUdp;
    rec.tcp_off    = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    rec.exp_status = StTcpOk;
    pick           = $urandom_range(0, 99);
    if (pick < 8) begin
      rec.kind = FrameNoise;
    end else if (pick < 12) begin
      rec.eth_type = 16'($urandom_range(0, 65535));
    end else if (pick < 16) begin
      rec.ver_ihl = 8'($urandom_range(0, 255));
    end else if (pick < 20) begin
      rec.frag[12:0] = 13'($urandom_range(1, 8191));
    end else if (pick < 26) begin
      rec.proto = 8'($urandom_range(0, 255));
    end else if (pick < 30) begin
      rec.proto   = ProtoTcp;
      rec.tcp_off = 4'($urandom_range(0, 15));
    end
    ihl  = rec.ver_ihl[3:0];
    full = EthHdrBytes + ((ihl >= 5) ? ihl * 4 : IpMinBytes);
    if (rec.proto == ProtoTcp) full += (rec.tcp_off >= 5) ? 32'(rec.tcp_off) * 4 : TcpMinBytes;
    else full += UdpHdrBytes;
    if ($urandom_range(0, 7) == 0) rec.len = full + $urandom_range(0, 200);
    else rec.len = full + $urandom_range(0, 24);
    if (pick >= 30 && pick < 42) rec.len = $urandom_range(1, full + 3);
    if (rec.kind == FrameNoise) rec.len = $urandom_range(1, 70);
    return rec;
  endfunction

  task automatic send_frame(input recipe_t rec);
    int unsigned p;
    logic [7:0]  b;
    bit          is_last;
    bit          got;
    summary_t    res;
    for (p = 0; p < rec.len; p++) begin
      b       = frame_byte(rec, p);
      is_last = (p == rec.len - 1);
      while (!steady && $urandom_range(0, 99) < 11) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= b;
      s_axis_tlast_i  <= is_last;
      do @(posedge clk_i); while (!s_axis_tready_o);
      bytes_sent++;
      parse_byte(b, is_last, got, res);
      if (got) begin
        if (rec.typed) begin
          res.status          = rec.exp_status;
          res.captured_length = rec.exp_cap;
        end
        pending_summaries.push_back(res);
      end
    end
    frames_sent++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_summary(input summary_t got);
    summary_t want;
    if (pending_summaries.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat, expected none actual %h", $time, got);
      return;
    end
    want = pending_summaries.pop_front();
    check_field("status", 64'(want.status), 64'(got.status));
    check_field("source_mac", 64'(want.source_mac), 64'(got.source_mac));
    check_field("dest_mac", 64'(want.dest_mac), 64'(got.dest_mac));
    check_field("eth_type", 64'(want.eth_type), 64'(got.eth_type));
    check_field("source_ip", 64'(want.source_ip), 64'(got.source_ip));
    check_field("dest_ip", 64'(want.dest_ip), 64'(got.dest_ip));
    check_field("ip_protocol", 64'(want.ip_protocol), 64'(got.ip_protocol));
    check_field("source_port", 64'(want.source_port), 64'(got.source_port));
    check_field("dest_port", 64'(want.dest_port), 64'(got.dest_port));
    check_field("header_length", 64'(want.header_length), 64'(got.header_length));
    check_field("payload_length", 64'(want.payload_length), 64'(got.payload_length));
    check_field("captured_length", 64'(want.captured_length), 64'(got.captured_length));
    check_field("padding", 64'(want.pad), 64'(got.pad));
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) check_summary(summary_t'(m_axis_tdata_o));
    m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 11);
  end

  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    steady          = 1'b0;
    errors          = 0;
    bytes_sent      = 0;
    frames_sent     = 0;
    clear_frame();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedFrames[i]) send_frame(DirectedFrames[i]);

    frames_sent = 0;
    while (bytes_sent < 1450) begin
      // one run of back-to-back frames with both sides always ready
      steady <= (frames_sent >= 2 && frames_sent < 7);
      send_frame(random_frame());
    end
    s_axis_tvalid_i <= 1'b0;
    steady          <= 1'b0;

    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
